// ===== src/fcc_pkg.sv =====
// shared types, constants and crc step function for the frame crc checker
`timescale 1ns / 1ps
package fcc_pkg;

  localparam int unsigned CRC_W      = 32;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned FLUSH_STG  = 4;

  localparam logic [CRC_W-1:0]  POLY_RESET  = 32'h04C1_1DB7;
  localparam logic [BYTE_W-1:0] NOCMD_RESET = 8'hFF;

  localparam logic [CFG_IDX_W-1:0] CFG_CRC_POLYNOMIAL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_COMMAND_CODE = 2'd1;

  localparam logic [1:0] POS_FIRST = 2'd0;
  localparam logic [1:0] POS_THIRD = 2'd2;
  localparam logic [1:0] POS_SAT   = 2'd3;

  typedef struct packed {
    logic [CRC_W-1:0]  rem;
    logic [BYTE_W-1:0] first;
    logic [BYTE_W-1:0] third;
  } frame_t;

  // eight bit steps, msb first, xor before shift
  function automatic logic [CRC_W-1:0] crc_shift8(input logic [CRC_W-1:0] r,
                                                  input logic [BYTE_W-1:0] d,
                                                  input logic [CRC_W-1:0] poly);
    logic [CRC_W-1:0] v;
    v = r;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      if (v[CRC_W-1]) begin
        v = v ^ poly;
      end
      v = {v[CRC_W-2:0], d[i]};
    end
    return v;
  endfunction

endpackage

// ===== src/fcc_if.sv =====
// valid/ready channel interfaces for frame bytes and check results
`timescale 1ns / 1ps
interface fcc_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface fcc_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] crc_value;
  logic        frame_good;
  logic [7:0]  command_code;
  logic [7:0]  phase_value;

  modport source (output valid, output crc_value, output frame_good, output command_code,
                  output phase_value, input ready);
  modport sink   (input valid, input crc_value, input frame_good, input command_code,
                  input phase_value, output ready);
endinterface

// ===== src/fcc_accum.sv =====
// byte accumulator: folds each byte into the running remainder and keeps bytes 0 and 2
`timescale 1ns / 1ps
module fcc_accum (
  input  logic                      clk,
  input  logic                      rst,
  fcc_frame_if.sink                 frame,
  input  logic                      advance,
  input  logic [fcc_pkg::CRC_W-1:0] poly,
  output fcc_pkg::frame_t           entry,
  output logic                      entry_valid
);
  import fcc_pkg::*;

  logic [CRC_W-1:0]  rem;
  logic [1:0]        pos;
  logic [BYTE_W-1:0] first;
  logic [BYTE_W-1:0] third;

  logic              fire;
  logic [CRC_W-1:0]  rem_next;
  logic [BYTE_W-1:0] first_next;
  logic [BYTE_W-1:0] third_next;
  logic [1:0]        pos_next;

  assign frame.ready = advance;
  assign fire        = frame.valid && advance;

  always_comb begin
    rem_next   = crc_shift8(rem, frame.data_byte, poly);
    first_next = (pos == POS_FIRST) ? frame.data_byte : first;
    third_next = (pos == POS_THIRD) ? frame.data_byte : third;
    pos_next   = (pos == POS_SAT) ? pos : pos + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem   <= '0;
      pos   <= '0;
      first <= '0;
      third <= '0;
    end else if (fire) begin
      if (frame.last_byte) begin
        rem   <= '0;
        pos   <= '0;
        first <= '0;
        third <= '0;
      end else begin
        rem   <= rem_next;
        pos   <= pos_next;
        first <= first_next;
        third <= third_next;
      end
    end
  end

  assign entry.rem   = rem_next;
  assign entry.first = first_next;
  assign entry.third = third_next;
  assign entry_valid = fire && frame.last_byte;

`ifndef SYNTH
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (fire && frame.last_byte) |=> (rem == '0 && pos == '0 && first == '0 && third == '0))
    else $error("frame state not cleared after last byte");
  a_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !fire |=> ($stable(rem) && $stable(pos)))
    else $error("frame state changed without a transfer");
  a_pos_first_seen: assert property (@(posedge clk) disable iff (rst)
    (pos == POS_FIRST) |-> (first == '0 && third == '0))
    else $error("captured bytes set at start of frame");
`endif
endmodule

// ===== src/fcc_flush.sv =====
// zero flush pipeline and result register, each but the first stage shifting in eight zero bits
`timescale 1ns / 1ps
module fcc_flush (
  input  logic                       clk,
  input  logic                       rst,
  input  fcc_pkg::frame_t            entry,
  input  logic                       entry_valid,
  input  logic [fcc_pkg::CRC_W-1:0]  poly,
  input  logic [fcc_pkg::BYTE_W-1:0] nocmd,
  output logic                       advance,
  fcc_result_if.source               result
);
  import fcc_pkg::*;

  frame_t           stage [FLUSH_STG];
  logic             stage_valid [FLUSH_STG];

  logic             out_valid;
  logic [CRC_W-1:0] out_crc;
  logic             out_ok;
  logic [BYTE_W-1:0] out_cmd;
  logic [BYTE_W-1:0] out_phase;

  logic [CRC_W-1:0] crc_next;
  logic             ok_next;

  assign advance = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < FLUSH_STG; k++) begin
        stage_valid[k] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else if (advance) begin
      stage_valid[0] <= entry_valid;
      for (int k = 1; k < FLUSH_STG; k++) begin
        stage_valid[k] <= stage_valid[k-1];
      end
      out_valid <= stage_valid[FLUSH_STG-1];
    end
  end

  always_comb begin
    crc_next = crc_shift8(stage[FLUSH_STG-1].rem, '0, poly);
    ok_next  = (crc_next == '0);
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      stage[0] <= entry;
      for (int k = 1; k < FLUSH_STG; k++) begin
        stage[k].rem   <= crc_shift8(stage[k-1].rem, '0, poly);
        stage[k].first <= stage[k-1].first;
        stage[k].third <= stage[k-1].third;
      end
      out_crc   <= crc_next;
      out_ok    <= ok_next;
      out_cmd   <= ok_next ? stage[FLUSH_STG-1].third : nocmd;
      out_phase <= ok_next ? stage[FLUSH_STG-1].first : '0;
    end
  end

  assign result.valid        = out_valid;
  assign result.crc_value    = out_crc;
  assign result.frame_good   = out_ok;
  assign result.command_code = out_cmd;
  assign result.phase_value  = out_phase;

`ifndef SYNTH
  a_ok_matches_crc: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_ok == (out_crc == '0)))
    else $error("frame_good disagrees with crc_value");
  a_fail_phase_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ok) |-> (out_phase == '0 && out_cmd == nocmd))
    else $error("failed frame reports command or phase");
  a_stall_holds_pipe: assert property (@(posedge clk) disable iff (rst)
    !advance |=> ($stable(stage_valid[0]) && $stable(stage_valid[FLUSH_STG-1])))
    else $error("flush pipeline moved during a stall");
`endif
endmodule

// ===== src/frame_crc32_checker.sv =====
// frame crc-32 checker top level: configuration registers and the two pipeline parts
//
// usage:
//   frame is a valid/ready channel of frame bytes, data_byte shifted in msb first,
//   last_byte high on the final byte. result carries one transfer per frame:
//   crc_value, frame_good, command_code (byte 2, or no_command_code on error) and
//   phase_value (byte 0, or zero on error).
//   the cfg port writes crc_polynomial (index 0) or no_command_code (index 1)
//   with cfg_we; other indexes are ignored. write only while the block is idle.
// timing:
//   one byte is taken every cycle while no result waits untaken. a frame's result
//   passes the four-stage zero flush pipeline and then the result register; each
//   stage after the first, and the result register, shifts in eight zero bits.
// reset and stall:
//   rst clears the frame state and pipeline valids and loads register defaults.
//   while a result waits untaken the whole pipeline holds and frame.ready is low;
//   the next byte is taken in the cycle the waiting result is taken.
`timescale 1ns / 1ps
module frame_crc32_checker (
  input  logic                          clk,
  input  logic                          rst,
  fcc_frame_if.sink                     frame,
  fcc_result_if.source                  result,
  input  logic                          cfg_we,
  input  logic [fcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fcc_pkg::CRC_W-1:0]     cfg_data
);
  import fcc_pkg::*;

  logic [CRC_W-1:0]  crc_polynomial;
  logic [BYTE_W-1:0] no_command_code;

  frame_t entry;
  logic   entry_valid;
  logic   advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_polynomial  <= POLY_RESET;
      no_command_code <= NOCMD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CRC_POLYNOMIAL:  crc_polynomial  <= cfg_data;
        CFG_NO_COMMAND_CODE: no_command_code <= cfg_data[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  fcc_accum u_accum (
    .clk         (clk),
    .rst         (rst),
    .frame       (frame),
    .advance     (advance),
    .poly        (crc_polynomial),
    .entry       (entry),
    .entry_valid (entry_valid)
  );

  fcc_flush u_flush (
    .clk         (clk),
    .rst         (rst),
    .entry       (entry),
    .entry_valid (entry_valid),
    .poly        (crc_polynomial),
    .nocmd       (no_command_code),
    .advance     (advance),
    .result      (result)
  );
endmodule
